FILE: src/ttrs_pkg.sv
// ttrs_pkg: shared types, constants and helpers of the time table relay scheduler
// no dependencies; used by every module under src
package ttrs_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 4;
  localparam int SEC_W       = 17;

  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  localparam int YEAR_MIN   = 20;
  localparam int YEAR_MAX   = 30;
  localparam int MONTH_MIN  = 1;
  localparam int MONTH_MAX  = 12;
  localparam int DAY_MIN    = 1;
  localparam int DAY_MAX    = 31;
  localparam int HOUR_MAX   = 23;
  localparam int MINSEC_MAX = 59;
  localparam int COUNT_MIN  = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_TIME  = 2'd1,
    STATUS_BAD_COUNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_GET_FIRST,
    ST_GET_LAST,
    ST_GET_TI,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic       command;
    logic [2:0] entry_index;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       relay_state_in;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [2:0] fired_entry;
    logic       relay_on;
  } out_item_t;

  typedef struct packed {
    logic             relay;
    logic [SEC_W-1:0] secs;
  } entry_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

  function automatic logic [SEC_W-1:0] to_seconds(logic [4:0] h, logic [5:0] m,
                                                  logic [5:0] s);
    logic [SEC_W-1:0] t;
    t = SEC_W'(h) * SEC_W'(SECS_PER_HOUR) + SEC_W'(m) * SEC_W'(SECS_PER_MIN) + SEC_W'(s);
    return t;
  endfunction

endpackage

FILE: src/ttrs_entry_ram.sv
// ttrs_entry_ram: schedule entry store, one write port, one registered read port
// depends on ttrs_pkg
module ttrs_entry_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ttrs_pkg::IDX_W-1:0] waddr,
  input  ttrs_pkg::entry_t           wdata,
  input  logic [ttrs_pkg::IDX_W-1:0] raddr,
  output ttrs_pkg::entry_t           rdata
);

  ttrs_pkg::entry_t mem [ttrs_pkg::TABLE_DEPTH];
  ttrs_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ttrs_cmp.sv
// ttrs_cmp: shared magnitude compare of the current time against one entry time
// depends on ttrs_pkg
module ttrs_cmp (
  input  logic [ttrs_pkg::SEC_W-1:0] now,
  input  logic [ttrs_pkg::SEC_W-1:0] ref_secs,
  output ttrs_pkg::cmp_t             res
);

  always_comb begin
    res.lt = now < ref_secs;
    res.gt = now > ref_secs;
  end

endmodule

FILE: src/time_table_relay_scheduler.sv
// time_table_relay_scheduler: top level, sequencer walking the schedule table
// depends on ttrs_pkg, ttrs_entry_ram, ttrs_cmp
//
// Usage: drive in_item and raise start; the beat is taken at a clock edge where
// start is high and busy is low. A load beat (command 0) writes one schedule
// entry; a tick beat (command 1) gives the current date and time. Every beat
// yields one result on out_item, shown for exactly one cycle with out_valid.
// The receiver cannot stall; the result must be taken when out_valid is high.
// cfg_we/cfg_wdata write entry_count at any edge with cfg_we high; write it
// only while the block is idle.
// A load beat passes ST_LOAD and a bad tick ST_CHECK; a tick outside the
// table goes on to ST_GET_FIRST and ST_GET_LAST, one inside on to ST_GET_TI
// and ST_STEP, stepping over at most entry_count - 2 entries. The walk reads
// one entry per cycle through the single read port of the entry store and
// tests it on one shared comparator. busy stays high until the result cycle,
// so the next beat may be accepted while the result is showing.
// Reset (rst_n low, synchronous) clears fired marks, walk index, entry_count
// and the control; schedule entries stay undefined until loaded.
module time_table_relay_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  ttrs_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output ttrs_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [ttrs_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = ttrs_pkg::IDX_W;
  localparam int SEC_W = ttrs_pkg::SEC_W;
  localparam int CNT_W = ttrs_pkg::COUNT_W;

  ttrs_pkg::state_t        state_r, state_nxt;
  ttrs_pkg::in_item_t      item_r, item_nxt;
  logic [SEC_W-1:0]        now_r, now_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [ttrs_pkg::TABLE_DEPTH-1:0] marks_r, marks_nxt;
  logic [IDX_W-1:0]        walk_r, walk_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    below_r, below_nxt;
  logic                    gt_ti_r, gt_ti_nxt;
  logic                    relay_ti_r, relay_ti_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ttrs_pkg::out_item_t     out_r, out_nxt;

  logic                    ram_we;
  ttrs_pkg::entry_t        ram_wdata;
  logic [IDX_W-1:0]        rd_addr;
  ttrs_pkg::entry_t        rd_data;
  ttrs_pkg::cmp_t          cmp;

  logic [IDX_W:0]          last_w;
  logic [IDX_W-1:0]        last;
  logic [IDX_W-1:0]        idx0;
  logic [IDX_W:0]          idx_inc;
  logic                    dt_ok;
  logic                    count_ok;

  ttrs_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_r.entry_index[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ttrs_cmp u_cmp (
    .now      (now_r),
    .ref_secs (rd_data.secs),
    .res      (cmp)
  );

  always_comb begin
    last_w   = {1'b0, count_r[IDX_W-1:0]} - (IDX_W+1)'(1);
    last     = last_w[IDX_W-1:0];
    idx0     = (walk_r >= last) ? '0 : walk_r;
    idx_inc  = {1'b0, idx_r} + (IDX_W+1)'(1);
    count_ok = (count_r >= CNT_W'(ttrs_pkg::COUNT_MIN)) &&
               (count_r <= CNT_W'(ttrs_pkg::TABLE_DEPTH));
    dt_ok    = (item_r.year >= 7'(ttrs_pkg::YEAR_MIN)) &&
               (item_r.year <= 7'(ttrs_pkg::YEAR_MAX)) &&
               (item_r.month >= 4'(ttrs_pkg::MONTH_MIN)) &&
               (item_r.month <= 4'(ttrs_pkg::MONTH_MAX)) &&
               (item_r.day >= 5'(ttrs_pkg::DAY_MIN)) &&
               (item_r.day <= 5'(ttrs_pkg::DAY_MAX)) &&
               (item_r.hour <= 5'(ttrs_pkg::HOUR_MAX)) &&
               (item_r.minute <= 6'(ttrs_pkg::MINSEC_MAX)) &&
               (item_r.second <= 6'(ttrs_pkg::MINSEC_MAX));
    ram_wdata.relay = item_r.relay_state_in;
    ram_wdata.secs  = now_r;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    now_nxt       = now_r;
    marks_nxt     = marks_r;
    walk_nxt      = walk_r;
    idx_nxt       = idx_r;
    below_nxt     = below_r;
    gt_ti_nxt     = gt_ti_r;
    relay_ti_nxt  = relay_ti_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ttrs_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          now_nxt   = ttrs_pkg::to_seconds(in_item.hour, in_item.minute, in_item.second);
          state_nxt = (in_item.command == ttrs_pkg::CMD_LOAD) ? ttrs_pkg::ST_LOAD
                                                              : ttrs_pkg::ST_CHECK;
        end
      end
      ttrs_pkg::ST_LOAD: begin
        ram_we        = ({1'b0, item_r.entry_index} < 4'(ttrs_pkg::TABLE_DEPTH));
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ttrs_pkg::STATUS_OK, default: '0};
        state_nxt     = ttrs_pkg::ST_IDLE;
      end
      ttrs_pkg::ST_CHECK: begin
        if (!dt_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ttrs_pkg::STATUS_BAD_TIME, default: '0};
          state_nxt     = ttrs_pkg::ST_IDLE;
        end else if (!count_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ttrs_pkg::STATUS_BAD_COUNT, default: '0};
          state_nxt     = ttrs_pkg::ST_IDLE;
        end else begin
          rd_addr   = '0;
          state_nxt = ttrs_pkg::ST_GET_FIRST;
        end
      end
      ttrs_pkg::ST_GET_FIRST: begin
        below_nxt = cmp.lt;
        rd_addr   = last;
        state_nxt = ttrs_pkg::ST_GET_LAST;
      end
      ttrs_pkg::ST_GET_LAST: begin
        if (below_r || cmp.gt) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ttrs_pkg::STATUS_OK, default: '0};
          state_nxt     = ttrs_pkg::ST_IDLE;
          if (!marks_r[last]) begin
            marks_nxt            = '0;
            marks_nxt[last]      = 1'b1;
            out_nxt.fired        = 1'b1;
            out_nxt.fired_entry  = 3'(last);
            out_nxt.relay_on     = rd_data.relay;
            walk_nxt             = '0;
          end else begin
            walk_nxt = idx0;
          end
        end else begin
          idx_nxt   = idx0;
          rd_addr   = idx0;
          state_nxt = ttrs_pkg::ST_GET_TI;
        end
      end
      ttrs_pkg::ST_GET_TI: begin
        gt_ti_nxt    = cmp.gt;
        relay_ti_nxt = rd_data.relay;
        rd_addr      = idx_inc[IDX_W-1:0];
        state_nxt    = ttrs_pkg::ST_STEP;
      end
      ttrs_pkg::ST_STEP: begin
        if (gt_ti_r && cmp.lt) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ttrs_pkg::STATUS_OK, default: '0};
          state_nxt     = ttrs_pkg::ST_IDLE;
          walk_nxt      = idx_r;
          if (!marks_r[idx_r]) begin
            marks_nxt           = '0;
            marks_nxt[idx_r]    = 1'b1;
            out_nxt.fired       = 1'b1;
            out_nxt.fired_entry = 3'(idx_r);
            out_nxt.relay_on    = relay_ti_r;
          end
        end else if (!cmp.lt) begin
          if (idx_inc >= {1'b0, last}) begin
            walk_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ttrs_pkg::STATUS_OK, default: '0};
            state_nxt     = ttrs_pkg::ST_IDLE;
          end else begin
            idx_nxt      = idx_inc[IDX_W-1:0];
            gt_ti_nxt    = cmp.gt;
            relay_ti_nxt = rd_data.relay;
            rd_addr      = idx_r + IDX_W'(2);
          end
        end else begin
          walk_nxt      = idx_r;
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ttrs_pkg::STATUS_OK, default: '0};
          state_nxt     = ttrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttrs_pkg::ST_IDLE;
      marks_r     <= '0;
      walk_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      marks_r     <= marks_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    now_r      <= now_nxt;
    idx_r      <= idx_nxt;
    below_r    <= below_nxt;
    gt_ti_r    <= gt_ti_nxt;
    relay_ti_r <= relay_ti_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != ttrs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_marks_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(marks_r))
    else $error("more than one fired mark set");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != ttrs_pkg::ST_IDLE))
    else $error("result without a beat in flight");

  a_fired_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fired |-> marks_r[out_r.fired_entry[IDX_W-1:0]])
    else $error("fired entry not marked");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fired |-> out_r.status == ttrs_pkg::STATUS_OK)
    else $error("fired with error status");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for time_table_relay_scheduler, loads schedules and replays ticks
// depends on ttrs_pkg and the scheduler rtl; a scoreboard class predicts every result beat
import ttrs_pkg::*;

class relay_schedule_board;
  logic [SEC_W-1:0]   slot_secs  [TABLE_DEPTH];
  logic               slot_relay [TABLE_DEPTH];
  logic               fire_mark  [TABLE_DEPTH];
  logic [IDX_W-1:0]   walk;
  logic [COUNT_W-1:0] count;
  out_item_t          awaited_results[$];
  int                 errors;

  function new();
    foreach (fire_mark[i]) begin
      fire_mark[i]  = 1'b0;
      slot_secs[i]  = '0;
      slot_relay[i] = 1'b0;
    end
    walk   = '0;
    count  = '0;
    errors = 0;
  endfunction

  function logic [SEC_W-1:0] day_secs(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    int unsigned t;
    t = 32'(h) * 3600 + 32'(m) * 60 + 32'(s);
    return SEC_W'(t);
  endfunction

  function bit stamp_ok(in_item_t it);
    if (it.year < YEAR_MIN || it.year > YEAR_MAX) return 1'b0;
    if (it.month < MONTH_MIN || it.month > MONTH_MAX) return 1'b0;
    if (it.day < DAY_MIN || it.day > DAY_MAX) return 1'b0;
    if (it.hour > HOUR_MAX || it.minute > MINSEC_MAX || it.second > MINSEC_MAX) return 1'b0;
    return 1'b1;
  endfunction

  function out_item_t fire_entry(int unsigned k);
    out_item_t r;
    foreach (fire_mark[i]) fire_mark[i] = 1'b0;
    fire_mark[k]  = 1'b1;
    r             = '0;
    r.status      = STATUS_OK;
    r.fired       = 1'b1;
    r.fired_entry = 3'(k);
    r.relay_on    = slot_relay[k];
    return r;
  endfunction

  function out_item_t schedule_outcome(in_item_t it);
    out_item_t        r;
    int unsigned      last;
    int unsigned      idx;
    logic [SEC_W-1:0] now;
    bit               done;
    r = '0;
    if (it.command == CMD_LOAD) begin
      slot_secs[it.entry_index]  = day_secs(it.hour, it.minute, it.second);
      slot_relay[it.entry_index] = it.relay_state_in;
      return r;
    end
    if (!stamp_ok(it)) begin
      r.status = STATUS_BAD_TIME;
      return r;
    end
    if (count < COUNT_MIN || count > TABLE_DEPTH) begin
      r.status = STATUS_BAD_COUNT;
      return r;
    end
    last = 32'(count) - 1;
    now  = day_secs(it.hour, it.minute, it.second);
    idx  = 32'(walk);
    done = 1'b0;
    while (!done) begin
      if (idx >= last) idx = 0;
      if (now < slot_secs[0] || now > slot_secs[last]) begin
        if (!fire_mark[last]) begin
          r   = fire_entry(last);
          idx = 0;
        end
        done = 1'b1;
      end else if (now > slot_secs[idx] && now < slot_secs[idx+1]) begin
        if (!fire_mark[idx]) r = fire_entry(idx);
        done = 1'b1;
      end else if (now >= slot_secs[idx+1]) begin
        idx++;
        if (idx >= last) begin
          idx  = 0;
          done = 1'b1;
        end
      end else begin
        done = 1'b1;
      end
    end
    walk = IDX_W'(idx);
    return r;
  endfunction

  function void note_input(in_item_t it);
    awaited_results.push_back(schedule_outcome(it));
  endfunction

  function void check_result(out_item_t got);
    out_item_t e;
    if (awaited_results.size() == 0) begin
      $error("result beat with nothing awaited: status %0d fired %0d", got.status, got.fired);
      errors++;
      return;
    end
    e = awaited_results.pop_front();
    if (got.status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, got.status);
      errors++;
    end
    if (got.fired !== e.fired) begin
      $error("fired: expected %0d, actual %0d", e.fired, got.fired);
      errors++;
    end
    if (got.fired_entry !== e.fired_entry) begin
      $error("fired_entry: expected %0d, actual %0d", e.fired_entry, got.fired_entry);
      errors++;
    end
    if (got.relay_on !== e.relay_on) begin
      $error("relay_on: expected %0d, actual %0d", e.relay_on, got.relay_on);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IN_W        = $bits(in_item_t);
  localparam int DAY_SECS    = 86400;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  relay_schedule_board board;
  int                  burst_left = 0;
  int                  cycles = 0;

  time_table_relay_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_item);
  end

  function automatic in_item_t load_beat(logic [2:0] slot, int unsigned secs, logic relay);
    in_item_t it;
    it.command        = CMD_LOAD;
    it.entry_index    = slot;
    it.hour           = 5'(secs / 3600);
    it.minute         = 6'((secs % 3600) / 60);
    it.second         = 6'(secs % 60);
    it.relay_state_in = relay;
    it.year           = 7'($urandom);
    it.month          = 4'($urandom);
    it.day            = 5'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_beat(int unsigned secs);
    in_item_t it;
    it.command        = CMD_TICK;
    it.entry_index    = 3'($urandom);
    it.hour           = 5'(secs / 3600);
    it.minute         = 6'((secs % 3600) / 60);
    it.second         = 6'(secs % 60);
    it.relay_state_in = 1'($urandom);
    it.year           = 7'($urandom_range(YEAR_MIN, YEAR_MAX));
    it.month          = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
    it.day            = 5'($urandom_range(DAY_MIN, DAY_MAX));
    return it;
  endfunction

  // bursts of back-to-back beats with random gaps between them
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(30, 80);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(0, 14);
      end
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_input(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (board.awaited_results.size() != 0 || busy);
    burst_left = 0;
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    board.count  = v;
  endtask

  initial begin
    in_item_t    it;
    int unsigned plan [8];
    int unsigned t;
    int unsigned span;
    int unsigned cur;
    int unsigned n;
    int unsigned r;
    int          random_items;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    board     = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // count still zero after reset, date check wins over count check
    send(tick_beat(43200));
    it = tick_beat(43200);
    it.year = 7'(YEAR_MIN - 1);
    send(it);

    it = load_beat(3'd7, 0, 1'b1);
    it.hour   = 5'd31;
    it.minute = 6'd63;
    it.second = 6'd63;
    send(it);
    plan = '{21600, 30600, 43200, 47730, 64800, 72000, 79200, 86399};
    for (int k = 0; k < 8; k++) send(load_beat(3'(k), plan[k], 1'(k)));

    write_count(4'd8);
    send(tick_beat(18000));
    send(tick_beat(21600));
    send(tick_beat(25200));
    send(tick_beat(36000));
    it = tick_beat(86399);
    it.year  = 7'(YEAR_MAX);
    it.month = 4'(MONTH_MAX);
    it.day   = 5'(DAY_MAX);
    send(it);
    it = tick_beat(0);
    it.year  = 7'(YEAR_MIN);
    it.month = 4'(MONTH_MIN);
    it.day   = 5'(DAY_MIN);
    send(it);
    it = tick_beat(50000); it.hour = 5'(HOUR_MAX + 1); send(it);
    it = tick_beat(50000); it.minute = 6'(MINSEC_MAX + 1); send(it);
    it = tick_beat(50000); it.second = 6'(MINSEC_MAX + 1); send(it);
    it = tick_beat(50000); it.month = 4'(MONTH_MIN - 1); send(it);
    it = tick_beat(50000); it.month = 4'(MONTH_MAX + 1); send(it);
    it = tick_beat(50000); it.day = 5'(DAY_MIN - 1); send(it);
    it = tick_beat(50000); it.year = 7'(YEAR_MAX + 1); send(it);

    write_count(4'd1);
    send(tick_beat(50000));
    write_count(4'd15);
    send(tick_beat(50000));
    write_count(4'd2);
    send(tick_beat(25000));
    send(tick_beat(40000));

    random_items = 0;
    while (random_items < 850) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, 8);
        if (n >= 2) n = n + 7;
      end else begin
        n = $urandom_range(2, 8);
      end
      write_count(4'(n));

      if (n >= 2 && n <= 8) begin
        t    = $urandom_range(0, 30000);
        span = (86399 - t) / n;
        for (int k = 0; k < int'(n); k++) begin
          plan[k] = t;
          send(load_beat(3'(k), t, 1'($urandom)));
          random_items++;
          if ($urandom_range(0, 19) != 0) t = t + $urandom_range(1, span);
        end
      end

      cur = $urandom_range(0, DAY_SECS - 1);
      repeat ($urandom_range(15, 50)) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          it = IN_W'({$urandom, $urandom});
          it.command = CMD_TICK;
          send(it);
        end else if (r < 12) begin
          it = IN_W'({$urandom, $urandom});
          it.command = CMD_LOAD;
          send(it);
        end else if (r < 18 && n >= 2 && n <= 8) begin
          t = plan[$urandom_range(0, n - 1)];
          if (r == 12 && t > 0) t = t - 1;
          if (r == 13 && t < DAY_SECS - 1) t = t + 1;
          send(tick_beat(t));
        end else begin
          send(tick_beat(cur));
          if ($urandom_range(0, 99) < 80) cur = (cur + $urandom_range(0, 3000)) % DAY_SECS;
          else cur = $urandom_range(0, DAY_SECS - 1);
        end
        random_items++;
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/ttrs_pkg.sv
src/ttrs_entry_ram.sv
src/ttrs_cmp.sv
src/time_table_relay_scheduler.sv
bench/tb.sv
